FILE: rtl/psn_pkg.sv
// ----------------------------------------------------------------------------
// Point-to-segment nearest point package
// Shared widths, payload types and the endpoint selection code for the
// nearest point pipeline.
// ----------------------------------------------------------------------------
package psn_pkg;

	// Input coordinate width and fraction bits of the nearest point.
	localparam int CB = 16;
	localparam int FB = 8;

	// Difference width, product width, squared length width, projection width.
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int LW = 2 * DW;
	localparam int NW = 2 * DW + 1;

	// Divider operands: magnitude of num * |d|, dividend, quotient bits.
	localparam int MW  = LW + CB;
	localparam int DVW = MW + FB;
	localparam int QW  = CB + FB + 1;

	// Output coordinate width, rounding adder width, squared distance width.
	localparam int OW  = CB + FB;
	localparam int AW  = OW + 2;
	localparam int DSW = 2 * OW + 1;

	// Which point the result is taken from.
	typedef enum logic [1:0] {
		SEL_START,
		SEL_END,
		SEL_FOOT
	} sel_t;

	typedef struct packed {
		logic signed [CB-1:0] point_x;
		logic signed [CB-1:0] point_y;
		logic signed [CB-1:0] seg_start_x;
		logic signed [CB-1:0] seg_start_y;
		logic signed [CB-1:0] seg_end_x;
		logic signed [CB-1:0] seg_end_y;
	} req_t;

	typedef struct packed {
		logic signed [OW-1:0] nearest_x;
		logic signed [OW-1:0] nearest_y;
		logic [DSW-1:0]       dist_squared;
	} result_t;

	// Context that rides along with the divider.
	typedef struct packed {
		sel_t                 sel;
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
		logic signed [CB-1:0] sx;
		logic signed [CB-1:0] sy;
		logic signed [CB-1:0] ex;
		logic signed [CB-1:0] ey;
		logic [LW-1:0]        len2;
		logic                 negx;
		logic                 negy;
	} ctx_t;

endpackage

FILE: rtl/point_segment_nearest_core.sv
// ----------------------------------------------------------------------------
// Point-to-segment nearest point core
// Nearest point on a 2-D segment to a query point and the squared distance.
// ----------------------------------------------------------------------------
// Usage:
// A request carries a query point and the two segment endpoints as signed
// 16-bit integers. It is taken on a rising edge with req_valid high and
// req_stall low. Each request gives exactly one result: the nearest point
// (8 fraction bits, rounded to nearest, ties away from zero) and the exact
// squared distance to that point (16 fraction bits), taken on an edge with
// result_valid high and result_stall low.
// The path from request to result runs through 4 geometry stages, 25 divider
// stages (one quotient bit each), 5 rounding and distance stages, and the
// output register. One request is taken every cycle while req_stall is low;
// the restoring divider sets the depth.
// When the receiver stalls, the output register holds and one more result
// goes into a skid entry; req_stall rises only while that entry is full, and
// the whole pipeline then holds its contents.
// Reset clears all valid bits and the output buffer; a stall loses no request.
// ----------------------------------------------------------------------------
module point_segment_nearest_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  psn_pkg::req_t       req,
	output logic                result_valid,
	input  logic                result_stall,
	output psn_pkg::result_t    result
);

	logic                       advance;
	logic                       geo_valid;
	psn_pkg::ctx_t              geo_ctx;
	logic [psn_pkg::MW-1:0]     mag_x, mag_y;
	logic                       div_valid;
	psn_pkg::ctx_t              div_ctx;
	logic [psn_pkg::QW-1:0]     quo_x, quo_y;
	logic [psn_pkg::LW-1:0]     rem_x, rem_y;

	// The pipeline holds only while the output skid entry is occupied.
	assign req_stall = !advance;

	psn_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.req_valid (req_valid),
		.req       (req),
		.geo_valid (geo_valid),
		.geo_ctx   (geo_ctx),
		.mag_x     (mag_x),
		.mag_y     (mag_y)
	);

	psn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.geo_valid (geo_valid),
		.geo_ctx   (geo_ctx),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.div_valid (div_valid),
		.div_ctx   (div_ctx),
		.quo_x     (quo_x),
		.quo_y     (quo_y),
		.rem_x     (rem_x),
		.rem_y     (rem_y)
	);

	psn_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.div_valid    (div_valid),
		.div_ctx      (div_ctx),
		.quo_x        (quo_x),
		.quo_y        (quo_y),
		.rem_x        (rem_x),
		.rem_y        (rem_y),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: rtl/psn_geom.sv
// ----------------------------------------------------------------------------
// Segment geometry front end
// Four stages: differences, products, squared length and projection, then
// endpoint classification and the divider's numerator magnitudes.
// ----------------------------------------------------------------------------
module psn_geom (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    req_valid,
	input  psn_pkg::req_t           req,
	output logic                    geo_valid,
	output psn_pkg::ctx_t           geo_ctx,
	output logic [psn_pkg::MW-1:0]  mag_x,
	output logic [psn_pkg::MW-1:0]  mag_y
);

	logic                           v_s1, v_s2, v_s3, v_s4;
	psn_pkg::req_t                  req_s1, req_s2, req_s3;
	logic signed [psn_pkg::DW-1:0]  wx_s1, wy_s1, dx_s1, dy_s1;
	logic signed [psn_pkg::DW-1:0]  dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [psn_pkg::PW-1:0]  dxx_s2, dyy_s2, wdx_s2, wdy_s2;
	logic [psn_pkg::LW-1:0]         len2_s3;
	logic signed [psn_pkg::NW-1:0]  num_s3;
	psn_pkg::ctx_t                  ctx_s4;
	logic [psn_pkg::MW-1:0]         mag_x_s4, mag_y_s4;

	logic [psn_pkg::DW-1:0]         adx_w, ady_w;
	psn_pkg::sel_t                  sel_w;

	// Valid bits move with the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Magnitudes of the direction and the endpoint selection.
	always_comb begin
		adx_w = dx_s3[psn_pkg::DW-1] ? psn_pkg::DW'(-dx_s3) : dx_s3;
		ady_w = dy_s3[psn_pkg::DW-1] ? psn_pkg::DW'(-dy_s3) : dy_s3;
		if (len2_s3 == '0 || num_s3 < 0) begin
			sel_w = psn_pkg::SEL_START;
		end else if (num_s3 > $signed(psn_pkg::NW'(len2_s3))) begin
			sel_w = psn_pkg::SEL_END;
		end else begin
			sel_w = psn_pkg::SEL_FOOT;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			req_s1 <= req;
			wx_s1  <= psn_pkg::DW'(req.point_x) - psn_pkg::DW'(req.seg_start_x);
			wy_s1  <= psn_pkg::DW'(req.point_y) - psn_pkg::DW'(req.seg_start_y);
			dx_s1  <= psn_pkg::DW'(req.seg_end_x) - psn_pkg::DW'(req.seg_start_x);
			dy_s1  <= psn_pkg::DW'(req.seg_end_y) - psn_pkg::DW'(req.seg_start_y);

			req_s2 <= req_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			wdx_s2 <= wx_s1 * dx_s1;
			wdy_s2 <= wy_s1 * dy_s1;

			req_s3  <= req_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			len2_s3 <= psn_pkg::LW'(dxx_s2 + dyy_s2);
			num_s3  <= psn_pkg::NW'(wdx_s2) + psn_pkg::NW'(wdy_s2);

			ctx_s4.sel  <= sel_w;
			ctx_s4.px   <= req_s3.point_x;
			ctx_s4.py   <= req_s3.point_y;
			ctx_s4.sx   <= req_s3.seg_start_x;
			ctx_s4.sy   <= req_s3.seg_start_y;
			ctx_s4.ex   <= req_s3.seg_end_x;
			ctx_s4.ey   <= req_s3.seg_end_y;
			ctx_s4.len2 <= len2_s3;
			ctx_s4.negx <= dx_s3[psn_pkg::DW-1];
			ctx_s4.negy <= dy_s3[psn_pkg::DW-1];
			mag_x_s4    <= num_s3[psn_pkg::LW-1:0] * adx_w[psn_pkg::CB-1:0];
			mag_y_s4    <= num_s3[psn_pkg::LW-1:0] * ady_w[psn_pkg::CB-1:0];
		end
	end

	assign geo_valid = v_s4;
	assign geo_ctx   = ctx_s4;
	assign mag_x     = mag_x_s4;
	assign mag_y     = mag_y_s4;

endmodule

FILE: rtl/psn_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides both scaled projections by the squared length, one quotient bit
// per stage, and hands on quotient and remainder for rounding.
// ----------------------------------------------------------------------------
module psn_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    geo_valid,
	input  psn_pkg::ctx_t           geo_ctx,
	input  logic [psn_pkg::MW-1:0]  mag_x,
	input  logic [psn_pkg::MW-1:0]  mag_y,
	output logic                    div_valid,
	output psn_pkg::ctx_t           div_ctx,
	output logic [psn_pkg::QW-1:0]  quo_x,
	output logic [psn_pkg::QW-1:0]  quo_y,
	output logic [psn_pkg::LW-1:0]  rem_x,
	output logic [psn_pkg::LW-1:0]  rem_y
);

	logic                           v_sn    [psn_pkg::QW];
	psn_pkg::ctx_t                  ctx_sn  [psn_pkg::QW];
	logic [psn_pkg::LW-1:0]         rem_sn  [psn_pkg::QW][2];
	logic [psn_pkg::QW-1:0]         low_sn  [psn_pkg::QW][2];
	logic [psn_pkg::QW-1:0]         quo_sn  [psn_pkg::QW][2];

	logic                           v_src   [psn_pkg::QW];
	psn_pkg::ctx_t                  ctx_src [psn_pkg::QW];
	logic [psn_pkg::LW-1:0]         rem_src [psn_pkg::QW][2];
	logic [psn_pkg::QW-1:0]         low_src [psn_pkg::QW][2];
	logic [psn_pkg::QW-1:0]         quo_src [psn_pkg::QW][2];
	logic [psn_pkg::LW-1:0]         rem_nx  [psn_pkg::QW][2];
	logic [psn_pkg::QW-1:0]         low_nx  [psn_pkg::QW][2];
	logic [psn_pkg::QW-1:0]         quo_nx  [psn_pkg::QW][2];
	logic [psn_pkg::DVW-1:0]        dvd     [2];

	// Stage inputs: the dividend enters at the first stage, the rest chain.
	always_comb begin
		dvd[0]     = psn_pkg::DVW'(mag_x) << psn_pkg::FB;
		dvd[1]     = psn_pkg::DVW'(mag_y) << psn_pkg::FB;
		v_src[0]   = geo_valid;
		ctx_src[0] = geo_ctx;
		for (int l = 0; l < 2; l++) begin
			rem_src[0][l] = {1'b0, dvd[l][psn_pkg::DVW-1:psn_pkg::QW]};
			low_src[0][l] = dvd[l][psn_pkg::QW-1:0];
			quo_src[0][l] = '0;
		end
		for (int k = 1; k < psn_pkg::QW; k++) begin
			v_src[k]   = v_sn[k-1];
			ctx_src[k] = ctx_sn[k-1];
			for (int l = 0; l < 2; l++) begin
				rem_src[k][l] = rem_sn[k-1][l];
				low_src[k][l] = low_sn[k-1][l];
				quo_src[k][l] = quo_sn[k-1][l];
			end
		end
	end

	// One shift, compare and subtract per stage and lane.
	always_comb begin
		logic [psn_pkg::LW:0] trial;
		logic                 qbit;
		for (int k = 0; k < psn_pkg::QW; k++) begin
			for (int l = 0; l < 2; l++) begin
				trial = {rem_src[k][l], low_src[k][l][psn_pkg::QW-1]};
				qbit  = trial >= {1'b0, ctx_src[k].len2};
				if (qbit) begin
					rem_nx[k][l] = psn_pkg::LW'(trial - {1'b0, ctx_src[k].len2});
				end else begin
					rem_nx[k][l] = trial[psn_pkg::LW-1:0];
				end
				low_nx[k][l] = {low_src[k][l][psn_pkg::QW-2:0], 1'b0};
				quo_nx[k][l] = {quo_src[k][l][psn_pkg::QW-2:0], qbit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < psn_pkg::QW; k++) begin
				v_sn[k] <= 1'b0;
			end
		end else if (advance) begin
			for (int k = 0; k < psn_pkg::QW; k++) begin
				v_sn[k] <= v_src[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < psn_pkg::QW; k++) begin
				ctx_sn[k] <= ctx_src[k];
				for (int l = 0; l < 2; l++) begin
					rem_sn[k][l] <= rem_nx[k][l];
					low_sn[k][l] <= low_nx[k][l];
					quo_sn[k][l] <= quo_nx[k][l];
				end
			end
		end
	end

	assign div_valid = v_sn[psn_pkg::QW-1];
	assign div_ctx   = ctx_sn[psn_pkg::QW-1];
	assign quo_x     = quo_sn[psn_pkg::QW-1][0];
	assign quo_y     = quo_sn[psn_pkg::QW-1][1];
	assign rem_x     = rem_sn[psn_pkg::QW-1][0];
	assign rem_y     = rem_sn[psn_pkg::QW-1][1];

endmodule

FILE: rtl/psn_tail.sv
// ----------------------------------------------------------------------------
// Rounding, distance and output buffer
// Turns quotient and remainder into the rounded nearest point, squares the
// offsets, and holds results in an output register with a skid entry.
// ----------------------------------------------------------------------------
module psn_tail (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    div_valid,
	input  psn_pkg::ctx_t           div_ctx,
	input  logic [psn_pkg::QW-1:0]  quo_x,
	input  logic [psn_pkg::QW-1:0]  quo_y,
	input  logic [psn_pkg::LW-1:0]  rem_x,
	input  logic [psn_pkg::LW-1:0]  rem_y,
	output logic                    advance,
	output logic                    result_valid,
	input  logic                    result_stall,
	output psn_pkg::result_t        result
);

	logic                              v_s1, v_s2, v_s3, v_s4, v_s5;
	psn_pkg::ctx_t                     ctx_s1, ctx_s2;
	logic signed [psn_pkg::QW:0]       qf_s1   [2];
	logic [psn_pkg::LW-1:0]            r_s1    [2];
	logic signed [psn_pkg::AW-1:0]     a_s2    [2];
	logic                              ge_s2   [2];
	logic                              gt_s2   [2];
	logic signed [psn_pkg::OW-1:0]     nx_s3   [2];
	logic signed [psn_pkg::CB-1:0]     p_s3    [2];
	logic signed [psn_pkg::OW-1:0]     nx_s4   [2];
	logic signed [psn_pkg::OW:0]       rx_s4   [2];
	logic signed [psn_pkg::OW-1:0]     nx_s5   [2];
	logic signed [2*psn_pkg::OW+1:0]   sq_s5   [2];

	logic [psn_pkg::QW-1:0]            quo_w   [2];
	logic [psn_pkg::LW-1:0]            rem_w   [2];
	logic                              neg_w   [2];
	logic signed [psn_pkg::CB-1:0]     s_w     [2];
	logic signed [psn_pkg::CB-1:0]     e_w     [2];
	logic signed [psn_pkg::CB-1:0]     p_w     [2];
	logic signed [psn_pkg::QW:0]       qf_w    [2];
	logic [psn_pkg::LW-1:0]            r_w     [2];
	logic signed [psn_pkg::OW-1:0]     nx_w    [2];
	logic [2*psn_pkg::OW+1:0]          dsum_w;
	psn_pkg::result_t                  res_w;

	logic                              out_v_q, skid_v_q;
	psn_pkg::result_t                  out_q, skid_q;

	// Lane views of the divider results and of the context.
	always_comb begin
		quo_w[0] = quo_x;
		quo_w[1] = quo_y;
		rem_w[0] = rem_x;
		rem_w[1] = rem_y;
		neg_w[0] = div_ctx.negx;
		neg_w[1] = div_ctx.negy;
		s_w[0]   = ctx_s2.sx;
		s_w[1]   = ctx_s2.sy;
		e_w[0]   = ctx_s2.ex;
		e_w[1]   = ctx_s2.ey;
		p_w[0]   = ctx_s2.px;
		p_w[1]   = ctx_s2.py;
	end

	// Floor quotient and remainder of the signed numerator.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (neg_w[l] && rem_w[l] != '0) begin
				qf_w[l] = -$signed({1'b0, quo_w[l]}) - $signed((psn_pkg::QW+1)'(1));
				r_w[l]  = div_ctx.len2 - rem_w[l];
			end else if (neg_w[l]) begin
				qf_w[l] = -$signed({1'b0, quo_w[l]});
				r_w[l]  = rem_w[l];
			end else begin
				qf_w[l] = $signed({1'b0, quo_w[l]});
				r_w[l]  = rem_w[l];
			end
		end
	end

	// Choose the endpoint or the rounded foot; ties round away from zero.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			case (ctx_s2.sel)
				psn_pkg::SEL_START: nx_w[l] = psn_pkg::OW'(s_w[l]) <<< psn_pkg::FB;
				psn_pkg::SEL_END:   nx_w[l] = psn_pkg::OW'(e_w[l]) <<< psn_pkg::FB;
				psn_pkg::SEL_FOOT: begin
					if (a_s2[l][psn_pkg::AW-1]) begin
						nx_w[l] = psn_pkg::OW'(a_s2[l] + psn_pkg::AW'(gt_s2[l]));
					end else begin
						nx_w[l] = psn_pkg::OW'(a_s2[l] + psn_pkg::AW'(ge_s2[l]));
					end
				end
				default:            nx_w[l] = psn_pkg::OW'(s_w[l]) <<< psn_pkg::FB;
			endcase
		end
	end

	// Result of the last stage as it enters the output buffer.
	always_comb begin
		dsum_w             = sq_s5[0] + sq_s5[1];
		res_w.nearest_x    = nx_s5[0];
		res_w.nearest_y    = nx_s5[1];
		res_w.dist_squared = dsum_w[psn_pkg::DSW-1:0];
	end

	assign advance = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= div_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctx_s1 <= div_ctx;
			ctx_s2 <= ctx_s1;
			for (int l = 0; l < 2; l++) begin
				qf_s1[l] <= qf_w[l];
				r_s1[l]  <= r_w[l];
				a_s2[l]  <= (psn_pkg::AW'(l == 0 ? ctx_s1.sx : ctx_s1.sy) <<< psn_pkg::FB)
					+ psn_pkg::AW'(qf_s1[l]);
				ge_s2[l] <= {r_s1[l], 1'b0} >= {1'b0, ctx_s1.len2};
				gt_s2[l] <= {r_s1[l], 1'b0} > {1'b0, ctx_s1.len2};
				nx_s3[l] <= nx_w[l];
				p_s3[l]  <= p_w[l];
				nx_s4[l] <= nx_s3[l];
				rx_s4[l] <= ((psn_pkg::OW+1)'(p_s3[l]) <<< psn_pkg::FB)
					- (psn_pkg::OW+1)'(nx_s3[l]);
				nx_s5[l] <= nx_s4[l];
				sq_s5[l] <= rx_s4[l] * rx_s4[l];
			end
		end
	end

	// Output register with one skid entry; the pipeline holds while it is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !result_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s5;
			end
		end else if (v_s5 && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !result_stall) begin
			out_q <= skid_v_q ? skid_q : res_w;
		end else if (!skid_v_q) begin
			skid_q <= res_w;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

`ifndef SYNTH
	// The skid entry is only ever occupied behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	// The skid entry fills only when the output was held by the receiver.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && result_stall))
		else $error("skid entry filled without a held output");

	// A drained skid entry moves into the output register.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !result_stall |=> out_v_q && !skid_v_q)
		else $error("skid entry not drained into output register");
`endif

endmodule

FILE: tb/psn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point result checker
// Watches the request and result channels of the nearest point core. Each
// accepted request is turned into an expected nearest point and squared
// distance, which are compared in order with the results the core returns.
// ----------------------------------------------------------------------------
module psn_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  psn_pkg::req_t    req,
	input  logic             result_valid,
	input  logic             result_stall,
	input  psn_pkg::result_t result,
	output int               fail_count,
	output int               pending_count,
	output int               result_count
);

	psn_pkg::result_t nearest_queue[$];

	// Quotient rounded to nearest with ties away from zero; den is positive.
	function automatic longint round_quot(longint num, longint den);
		longint mag;
		longint q;
		begin
			mag = (num < 0) ? -num : num;
			q = (2 * mag + den) / (2 * den);
			return (num < 0) ? -q : q;
		end
	endfunction

	// Nearest point on the segment and the exact squared distance to it.
	function automatic psn_pkg::result_t nearest_point(psn_pkg::req_t r);
		longint px, py, sx, sy, ex, ey, dx, dy, len2, proj, nx, ny, rx, ry;
		psn_pkg::result_t res;
		begin
			px = r.point_x;
			py = r.point_y;
			sx = r.seg_start_x;
			sy = r.seg_start_y;
			ex = r.seg_end_x;
			ey = r.seg_end_y;
			dx = ex - sx;
			dy = ey - sy;
			len2 = dx * dx + dy * dy;
			nx = sx <<< psn_pkg::FB;
			ny = sy <<< psn_pkg::FB;
			if (len2 != 0) begin
				proj = (px - sx) * dx + (py - sy) * dy;
				if (proj > len2) begin
					nx = ex <<< psn_pkg::FB;
					ny = ey <<< psn_pkg::FB;
				end else if (proj >= 0) begin
					nx = round_quot(((sx * len2) <<< psn_pkg::FB)
						+ ((proj * dx) <<< psn_pkg::FB), len2);
					ny = round_quot(((sy * len2) <<< psn_pkg::FB)
						+ ((proj * dy) <<< psn_pkg::FB), len2);
				end
			end
			rx = (px <<< psn_pkg::FB) - nx;
			ry = (py <<< psn_pkg::FB) - ny;
			res.nearest_x = nx[psn_pkg::OW-1:0];
			res.nearest_y = ny[psn_pkg::OW-1:0];
			res.dist_squared = psn_pkg::DSW'(rx * rx + ry * ry);
			return res;
		end
	endfunction

	// Predict on each accepted request and compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		psn_pkg::result_t exp_res;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
			pending_count <= 0;
		end else begin
			errs = 0;
			if (req_valid && !req_stall)
				nearest_queue.push_back(nearest_point(req));
			if (result_valid && !result_stall) begin
				result_count <= result_count + 1;
				if (nearest_queue.size() == 0) begin
					$error("unexpected result with nothing outstanding");
					errs++;
				end else begin
					exp_res = nearest_queue.pop_front();
					if (result.nearest_x !== exp_res.nearest_x) begin
						$error("nearest_x expected %0d got %0d",
							exp_res.nearest_x, result.nearest_x);
						errs++;
					end
					if (result.nearest_y !== exp_res.nearest_y) begin
						$error("nearest_y expected %0d got %0d",
							exp_res.nearest_y, result.nearest_y);
						errs++;
					end
					if (result.dist_squared !== exp_res.dist_squared) begin
						$error("dist_squared expected %0d got %0d",
							exp_res.dist_squared, result.dist_squared);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= nearest_queue.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point core testbench
// Sends directed and random point and segment requests with random gaps and
// receiver stalls; a checker predicts each result and compares in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int RANDOM_REQS = 800;
	localparam int LATENCY = 35;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	psn_pkg::req_t    req;
	logic             result_valid;
	logic             result_stall;
	psn_pkg::result_t result;
	int               fail_count;
	int               pending_count;
	int               result_count;
	psn_pkg::req_t    directed_reqs[$];

	point_segment_nearest_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	psn_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [psn_pkg::CB-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return psn_pkg::CB'(32'h8000 + $urandom_range(0, 3));
			1: return psn_pkg::CB'(32'h7fff - $urandom_range(0, 3));
			2: return psn_pkg::CB'($urandom_range(0, 40) - 20);
			default: return psn_pkg::CB'($urandom());
		endcase
	endfunction

	// Random request: a random point, an arbitrary segment, or a short or
	// degenerate one so that every selection path is exercised.
	function automatic psn_pkg::req_t rand_req();
		psn_pkg::req_t r;
		begin
			r.point_x = rand_coord();
			r.point_y = rand_coord();
			r.seg_start_x = rand_coord();
			r.seg_start_y = rand_coord();
			case ($urandom_range(0, 5))
				0: begin
					r.seg_end_x = r.seg_start_x;
					r.seg_end_y = r.seg_start_y;
				end
				1: begin
					r.seg_end_x = r.seg_start_x + psn_pkg::CB'($urandom_range(0, 6))
						- psn_pkg::CB'(3);
					r.seg_end_y = r.seg_start_y + psn_pkg::CB'($urandom_range(0, 6))
						- psn_pkg::CB'(3);
				end
				default: begin
					r.seg_end_x = rand_coord();
					r.seg_end_y = rand_coord();
				end
			endcase
			return r;
		end
	endfunction

	function automatic psn_pkg::req_t make_req(int px, int py, int sx, int sy, int ex, int ey);
		psn_pkg::req_t r;
		begin
			r.point_x = psn_pkg::CB'(px);
			r.point_y = psn_pkg::CB'(py);
			r.seg_start_x = psn_pkg::CB'(sx);
			r.seg_start_y = psn_pkg::CB'(sy);
			r.seg_end_x = psn_pkg::CB'(ex);
			r.seg_end_y = psn_pkg::CB'(ey);
			return r;
		end
	endfunction

	// Present one request after a random gap and hold it until taken.
	task automatic send_req(psn_pkg::req_t r);
		int gap;
		begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_valid <= 1'b1;
			req <= r;
			@(posedge clk);
			while (req_stall) @(posedge clk);
		end
	endtask

	// Receiver stalls: runs of random stall lengths with stall-free stretches.
	initial begin
		int wait_cycles;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
			if (wait_cycles != 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		int waited;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-length segments, including at the extremes of the range.
		directed_reqs.push_back(make_req(5, -7, 3, 3, 3, 3));
		directed_reqs.push_back(make_req(32767, 32767, -32768, -32768, -32768, -32768));
		// Foot before the start, beyond the end, on the segment, at each end.
		directed_reqs.push_back(make_req(-10, 0, 0, 0, 10, 0));
		directed_reqs.push_back(make_req(20, 5, 0, 0, 10, 0));
		directed_reqs.push_back(make_req(4, 9, 0, 0, 10, 0));
		directed_reqs.push_back(make_req(0, 9, 0, 0, 10, 0));
		directed_reqs.push_back(make_req(10, -9, 0, 0, 10, 0));
		// Fractional foot, including values just short of a rounding tie in both signs.
		directed_reqs.push_back(make_req(1, 0, 0, 0, 3, 1));
		directed_reqs.push_back(make_req(0, 1, 0, 0, 512, 1));
		directed_reqs.push_back(make_req(0, -1, 0, 0, -512, -1));
		directed_reqs.push_back(make_req(1, 2, -3, 7, 11, -5));
		// Full-range extremes.
		directed_reqs.push_back(make_req(32767, -32768, -32768, 32767, 32767, -32768));
		directed_reqs.push_back(make_req(-32768, -32768, 32767, 32767, 32767, 32767));
		directed_reqs.push_back(make_req(-32768, 32767, -32768, -32768, 32767, 32767));
		directed_reqs.push_back(make_req(32767, 32767, -32768, -32768, 32767, -32768));
		directed_reqs.push_back(make_req(0, 0, -32768, 32767, 32767, -32768));
		directed_reqs.push_back(make_req(-1, -1, 32767, -32768, -32768, 32767));
		foreach (directed_reqs[i]) send_req(directed_reqs[i]);

		for (int i = 0; i < RANDOM_REQS; i++) send_req(rand_req());
		req_valid <= 1'b0;

		// Drain, then let the pipeline settle.
		waited = 0;
		while (pending_count != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);

		$display("Sent %0d point-to-segment requests (directed and random)",
			directed_reqs.size() + RANDOM_REQS);
		$display("with random gaps and receiver stalls; checked %0d results.",
			result_count);
		if (fail_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
